FILE: sv/h2fsv_pkg.sv
// Shared definitions for the HTTP/2 frame stream validator.
// Frame type, phase, action and error codes; controller/datapath handshake structs.
// No dependencies.
package h2fsv_pkg;

    localparam int ID_W         = 31;
    localparam int TYPE_W       = 4;
    localparam int PHASE_W      = 3;
    localparam int ACT_W        = 3;
    localparam int SCOPE_W      = 2;
    localparam int KIND_W       = 2;
    localparam int STREAM_SLOTS = 16;

    // frame types
    localparam logic [TYPE_W-1:0] FT_DATA     = 4'd0;
    localparam logic [TYPE_W-1:0] FT_HEADERS  = 4'd1;
    localparam logic [TYPE_W-1:0] FT_PRIORITY = 4'd2;
    localparam logic [TYPE_W-1:0] FT_RST      = 4'd3;
    localparam logic [TYPE_W-1:0] FT_SETTINGS = 4'd4;
    localparam logic [TYPE_W-1:0] FT_PUSH     = 4'd5;
    localparam logic [TYPE_W-1:0] FT_PING     = 4'd6;
    localparam logic [TYPE_W-1:0] FT_GOAWAY   = 4'd7;
    localparam logic [TYPE_W-1:0] FT_WINDOW   = 4'd8;
    localparam logic [TYPE_W-1:0] FT_CONT     = 4'd9;

    // stream lifecycle phases
    localparam logic [PHASE_W-1:0] PH_IDLE     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_OPEN     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_HCLOCAL  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_HCREMOTE = 3'd5;
    localparam logic [PHASE_W-1:0] PH_CLOSED   = 3'd6;

    // result codes
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DELIVER = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WINDOW  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RST     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_GOAWAY  = 3'd4;

    localparam logic [SCOPE_W-1:0] SC_NONE   = 2'd0;
    localparam logic [SCOPE_W-1:0] SC_CONN   = 2'd1;
    localparam logic [SCOPE_W-1:0] SC_STREAM = 2'd2;

    localparam logic [KIND_W-1:0] EK_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] EK_PROTO = 2'd1;
    localparam logic [KIND_W-1:0] EK_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic lookup;
        logic commit;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // remote side ended the stream
    function automatic logic [PHASE_W-1:0] end_remote(input logic [PHASE_W-1:0] ph);
        logic [PHASE_W-1:0] r;
        r = ph;
        if (ph == PH_IDLE || ph == PH_OPEN) begin
            r = PH_HCREMOTE;
        end else if (ph == PH_HCLOCAL) begin
            r = PH_CLOSED;
        end
        return r;
    endfunction

endpackage

FILE: sv/http2_frame_stream_validator.sv
// HTTP/2 frame stream validator top level: one frame header in, one verdict out.
// Each frame is captured, matched in the stream table, then decided and committed.
// One frame at a time: the next is taken only after the capture/match/commit sequence
// over the stream table ends; a waiting result stalls only the decide step.
// Reset: synchronous active-low aresetn empties the stream table and clears
// CONTINUATION and GOAWAY tracking at once; no clearing pass.
module http2_frame_stream_validator #(
    parameter int STREAM_SLOTS = h2fsv_pkg::STREAM_SLOTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [h2fsv_pkg::TYPE_W-1:0]        s_frame_type,
    input  logic [h2fsv_pkg::ID_W-1:0]          s_stream_id,
    input  logic                                s_end_stream,
    input  logic                                s_end_headers,
    input  logic [h2fsv_pkg::ID_W-1:0]          s_goaway_last_id,
    input  logic [h2fsv_pkg::ID_W-1:0]          s_window_increment,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [h2fsv_pkg::ACT_W-1:0]         m_action,
    output logic [h2fsv_pkg::ID_W-1:0]          m_action_stream,
    output logic                                m_accepted,
    output logic [h2fsv_pkg::SCOPE_W-1:0]       m_error_scope,
    output logic [h2fsv_pkg::KIND_W-1:0]        m_error_kind
);

    h2fsv_pkg::ctl_cmd_t cmd;
    h2fsv_pkg::dp_stat_t stat;

    h2fsv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    h2fsv_dp #(
        .SLOTS (STREAM_SLOTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_frame_type       (s_frame_type),
        .s_stream_id        (s_stream_id),
        .s_end_stream       (s_end_stream),
        .s_end_headers      (s_end_headers),
        .s_goaway_last_id   (s_goaway_last_id),
        .s_window_increment (s_window_increment),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_action           (m_action),
        .m_action_stream    (m_action_stream),
        .m_accepted         (m_accepted),
        .m_error_scope      (m_error_scope),
        .m_error_kind       (m_error_kind)
    );

endmodule

FILE: sv/h2fsv_ctrl.sv
// Sequencing controller for the frame stream validator.
// Steps each frame through capture, table lookup and decide/commit. Uses h2fsv_pkg.
module h2fsv_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  h2fsv_pkg::dp_stat_t stat,
    output h2fsv_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready     = ready_reg;
    assign cmd.load_in = ready_reg && s_valid;
    assign cmd.lookup  = (state_reg == ST_LOOKUP);
    assign cmd.commit  = (state_reg == ST_DECIDE) && stat.out_free;

endmodule

FILE: sv/h2fsv_dp.sv
// Datapath of the frame stream validator: frame capture, stream table,
// connection state, rule checks and result register. Uses h2fsv_pkg.
module h2fsv_dp #(
    parameter int SLOTS = h2fsv_pkg::STREAM_SLOTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  h2fsv_pkg::ctl_cmd_t                 cmd,
    output h2fsv_pkg::dp_stat_t                 stat,
    input  logic [h2fsv_pkg::TYPE_W-1:0]        s_frame_type,
    input  logic [h2fsv_pkg::ID_W-1:0]          s_stream_id,
    input  logic                                s_end_stream,
    input  logic                                s_end_headers,
    input  logic [h2fsv_pkg::ID_W-1:0]          s_goaway_last_id,
    input  logic [h2fsv_pkg::ID_W-1:0]          s_window_increment,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [h2fsv_pkg::ACT_W-1:0]         m_action,
    output logic [h2fsv_pkg::ID_W-1:0]          m_action_stream,
    output logic                                m_accepted,
    output logic [h2fsv_pkg::SCOPE_W-1:0]       m_error_scope,
    output logic [h2fsv_pkg::KIND_W-1:0]        m_error_kind
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int IDW   = h2fsv_pkg::ID_W;
    localparam int PHW   = h2fsv_pkg::PHASE_W;

    // captured frame
    logic [h2fsv_pkg::TYPE_W-1:0] type_reg;
    logic [IDW-1:0]               sid_reg;
    logic                         es_reg;
    logic                         eh_reg;
    logic [IDW-1:0]               glast_reg;
    logic [IDW-1:0]               winc_reg;

    // stream table; slots fill from the bottom and are never freed,
    // so slot i is in use exactly when i < fill_cnt_reg
    logic [IDW-1:0]   slot_stream_reg [SLOTS];
    logic [PHW-1:0]   slot_phase_reg  [SLOTS];
    logic [CNT_W-1:0] fill_cnt_reg;

    // connection state
    logic           await_reg;
    logic [IDW-1:0] cont_sid_reg;
    logic           goaway_seen_reg;
    logic [IDW-1:0] goaway_limit_reg;
    logic [IDW-1:0] highest_reg;

    // lookup result
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [PHW-1:0]   hit_phase_reg, hit_phase_next;

    // result register
    logic                            m_valid_reg;
    logic [h2fsv_pkg::ACT_W-1:0]     act_reg;
    logic [IDW-1:0]                  act_sid_reg;
    logic                            ok_reg;
    logic [h2fsv_pkg::SCOPE_W-1:0]   scope_reg;
    logic [h2fsv_pkg::KIND_W-1:0]    kind_reg;

    // parallel match; at most one used slot holds a given id
    always_comb begin
        hit_next       = 1'b0;
        hit_idx_next   = '0;
        hit_phase_next = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (CNT_W'(i) < fill_cnt_reg && slot_stream_reg[i] == sid_reg) begin
                hit_next       = 1'b1;
                hit_idx_next   = hit_idx_next | IDX_W'(i);
                hit_phase_next = hit_phase_next | slot_phase_reg[i];
            end
        end
    end

    // decision
    logic                          full;
    logic                          need_nz, need_z;
    logic [PHW-1:0]                ph;
    logic [h2fsv_pkg::ACT_W-1:0]   r_act;
    logic [IDW-1:0]                r_sid;
    logic                          r_ok;
    logic [h2fsv_pkg::SCOPE_W-1:0] r_scope;
    logic [h2fsv_pkg::KIND_W-1:0]  r_kind;
    logic                          wr_en, alloc;
    logic [IDX_W-1:0]              wr_idx;
    logic [PHW-1:0]                wr_phase;
    logic                          set_cont, clr_cont, set_goaway, hi_upd;

    assign full    = (fill_cnt_reg == CNT_W'(SLOTS));
    assign need_nz = type_reg == h2fsv_pkg::FT_DATA || type_reg == h2fsv_pkg::FT_HEADERS
                  || type_reg == h2fsv_pkg::FT_PRIORITY || type_reg == h2fsv_pkg::FT_RST
                  || type_reg == h2fsv_pkg::FT_CONT;
    assign need_z  = type_reg == h2fsv_pkg::FT_SETTINGS || type_reg == h2fsv_pkg::FT_PING
                  || type_reg == h2fsv_pkg::FT_GOAWAY;

    always_comb begin
        r_act      = h2fsv_pkg::ACT_NONE;
        r_sid      = '0;
        r_ok       = 1'b1;
        r_scope    = h2fsv_pkg::SC_NONE;
        r_kind     = h2fsv_pkg::EK_NONE;
        wr_en      = 1'b0;
        alloc      = 1'b0;
        wr_idx     = hit_reg ? hit_idx_reg : fill_cnt_reg[IDX_W-1:0];
        wr_phase   = hit_phase_reg;
        set_cont   = 1'b0;
        clr_cont   = 1'b0;
        set_goaway = 1'b0;
        hi_upd     = 1'b0;
        ph         = hit_reg ? hit_phase_reg : h2fsv_pkg::PH_IDLE;

        if ((need_nz && sid_reg == '0) || (need_z && sid_reg != '0)
            || (await_reg && (type_reg != h2fsv_pkg::FT_CONT || sid_reg != cont_sid_reg))) begin
            r_act = h2fsv_pkg::ACT_GOAWAY; r_ok = 1'b0;
            r_scope = h2fsv_pkg::SC_CONN; r_kind = h2fsv_pkg::EK_PROTO;
        end else if (type_reg == h2fsv_pkg::FT_HEADERS && goaway_seen_reg
                     && sid_reg > goaway_limit_reg && !hit_reg) begin
            r_act = h2fsv_pkg::ACT_RST; r_sid = sid_reg; r_ok = 1'b0;
            r_scope = h2fsv_pkg::SC_STREAM; r_kind = h2fsv_pkg::EK_PROTO;
        end else begin
            case (type_reg) inside
                h2fsv_pkg::FT_HEADERS: begin
                    if (!hit_reg && full) begin
                        r_act = h2fsv_pkg::ACT_RST; r_sid = sid_reg; r_ok = 1'b0;
                        r_scope = h2fsv_pkg::SC_STREAM; r_kind = h2fsv_pkg::EK_FULL;
                    end else if (ph == h2fsv_pkg::PH_HCREMOTE || ph == h2fsv_pkg::PH_CLOSED) begin
                        r_act = h2fsv_pkg::ACT_RST; r_sid = sid_reg; r_ok = 1'b0;
                        r_scope = h2fsv_pkg::SC_STREAM; r_kind = h2fsv_pkg::EK_PROTO;
                    end else begin
                        if (ph == h2fsv_pkg::PH_IDLE) begin
                            ph     = h2fsv_pkg::PH_OPEN;
                            hi_upd = sid_reg > highest_reg;
                        end
                        if (es_reg) begin
                            ph = h2fsv_pkg::end_remote(ph);
                        end
                        wr_en    = 1'b1;
                        alloc    = !hit_reg;
                        wr_phase = ph;
                        set_cont = !eh_reg;
                        clr_cont = eh_reg;
                        r_act    = h2fsv_pkg::ACT_DELIVER;
                        r_sid    = sid_reg;
                    end
                end
                h2fsv_pkg::FT_DATA: begin
                    if (!hit_reg || (hit_phase_reg != h2fsv_pkg::PH_OPEN
                                     && hit_phase_reg != h2fsv_pkg::PH_HCLOCAL)) begin
                        r_act = h2fsv_pkg::ACT_RST; r_sid = sid_reg; r_ok = 1'b0;
                        r_scope = h2fsv_pkg::SC_STREAM; r_kind = h2fsv_pkg::EK_PROTO;
                    end else begin
                        wr_en    = es_reg;
                        wr_phase = h2fsv_pkg::end_remote(hit_phase_reg);
                        r_act    = h2fsv_pkg::ACT_DELIVER;
                        r_sid    = sid_reg;
                    end
                end
                h2fsv_pkg::FT_CONT: begin
                    if (!await_reg || sid_reg != cont_sid_reg) begin
                        r_act = h2fsv_pkg::ACT_GOAWAY; r_ok = 1'b0;
                        r_scope = h2fsv_pkg::SC_CONN; r_kind = h2fsv_pkg::EK_PROTO;
                    end else begin
                        clr_cont = eh_reg;
                        r_act    = h2fsv_pkg::ACT_DELIVER;
                        r_sid    = sid_reg;
                    end
                end
                h2fsv_pkg::FT_RST: begin
                    if (!hit_reg && full) begin
                        r_act = h2fsv_pkg::ACT_RST; r_sid = sid_reg; r_ok = 1'b0;
                        r_scope = h2fsv_pkg::SC_STREAM; r_kind = h2fsv_pkg::EK_FULL;
                    end else begin
                        wr_en    = 1'b1;
                        alloc    = !hit_reg;
                        wr_phase = h2fsv_pkg::PH_CLOSED;
                        r_act    = h2fsv_pkg::ACT_DELIVER;
                        r_sid    = sid_reg;
                    end
                end
                h2fsv_pkg::FT_GOAWAY: begin
                    set_goaway = 1'b1;
                end
                h2fsv_pkg::FT_WINDOW: begin
                    if (winc_reg == '0) begin
                        r_ok = 1'b0;
                        r_kind = h2fsv_pkg::EK_PROTO;
                        if (sid_reg == '0) begin
                            r_act = h2fsv_pkg::ACT_GOAWAY; r_scope = h2fsv_pkg::SC_CONN;
                        end else begin
                            r_act = h2fsv_pkg::ACT_RST; r_sid = sid_reg;
                            r_scope = h2fsv_pkg::SC_STREAM;
                        end
                    end else begin
                        r_act = h2fsv_pkg::ACT_WINDOW;
                        r_sid = sid_reg;
                    end
                end
                h2fsv_pkg::FT_PRIORITY, h2fsv_pkg::FT_PUSH: begin
                    r_act = h2fsv_pkg::ACT_DELIVER;
                    r_sid = sid_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            type_reg  <= s_frame_type;
            sid_reg   <= s_stream_id;
            es_reg    <= s_end_stream;
            eh_reg    <= s_end_headers;
            glast_reg <= s_goaway_last_id;
            winc_reg  <= s_window_increment;
        end
        if (cmd.lookup) begin
            hit_reg       <= hit_next;
            hit_idx_reg   <= hit_idx_next;
            hit_phase_reg <= hit_phase_next;
        end
        if (cmd.commit && wr_en) begin
            slot_stream_reg[wr_idx] <= sid_reg;
            slot_phase_reg[wr_idx]  <= wr_phase;
        end
        if (cmd.commit) begin
            act_reg     <= r_act;
            act_sid_reg <= r_sid;
            ok_reg      <= r_ok;
            scope_reg   <= r_scope;
            kind_reg    <= r_kind;
        end
    end

    // control and connection state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_cnt_reg     <= '0;
            await_reg        <= 1'b0;
            cont_sid_reg     <= '0;
            goaway_seen_reg  <= 1'b0;
            goaway_limit_reg <= '0;
            highest_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.commit) begin
                if (alloc) begin
                    fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
                end
                if (set_cont) begin
                    await_reg    <= 1'b1;
                    cont_sid_reg <= sid_reg;
                end else if (clr_cont) begin
                    await_reg    <= 1'b0;
                    cont_sid_reg <= '0;
                end
                if (set_goaway) begin
                    goaway_seen_reg  <= 1'b1;
                    goaway_limit_reg <= glast_reg;
                end
                if (hi_upd) begin
                    highest_reg <= sid_reg;
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free   = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_action        = act_reg;
    assign m_action_stream = act_sid_reg;
    assign m_accepted      = ok_reg;
    assign m_error_scope   = scope_reg;
    assign m_error_kind    = kind_reg;

endmodule

FILE: sv/h2fsv_checker.sv
// Port-level checks for the frame stream validator, bound to the top level.
// Uses h2fsv_pkg codes.
module h2fsv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [h2fsv_pkg::ACT_W-1:0]   m_action,
    input logic [h2fsv_pkg::ID_W-1:0]    m_action_stream,
    input logic                          m_accepted,
    input logic [h2fsv_pkg::SCOPE_W-1:0] m_error_scope,
    input logic [h2fsv_pkg::KIND_W-1:0]  m_error_kind
);

    // a pending result is not withdrawn
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // one frame in flight: no second input transfer right after one
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after a transfer");

    a_conn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == h2fsv_pkg::ACT_GOAWAY |->
            m_action_stream == '0 && !m_accepted && m_error_scope == h2fsv_pkg::SC_CONN)
        else $error("goaway result without connection error");

    a_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |->
            m_error_scope == h2fsv_pkg::SC_NONE && m_error_kind == h2fsv_pkg::EK_NONE)
        else $error("accepted frame carries an error");

endmodule

bind http2_frame_stream_validator h2fsv_checker u_h2fsv_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_action        (m_action),
    .m_action_stream (m_action_stream),
    .m_accepted      (m_accepted),
    .m_error_scope   (m_error_scope),
    .m_error_kind    (m_error_kind)
);
